### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### sv/twtm_pkg.sv
// ----------------------------------------------------------------------------
// twtm_pkg
// types, sizes and helper functions of the timing wheel timeout manager
// ----------------------------------------------------------------------------
`default_nettype none

package twtm_pkg;

	localparam int WHEEL_SLOTS = 60;
	localparam int MAX_TIMERS  = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam int ID_W    = 6;
	localparam int DELAY_W = 6;
	localparam int KIND_W  = 2;
	localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
	localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int DELAY_CODES = 1 << DELAY_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD     = 2'd0,
		KIND_REFRESH = 2'd1,
		KIND_CANCEL  = 2'd2,
		KIND_TICK    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REFRESH,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_END
	} back_state_t;

	// command word held in the queue
	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  idx;
		logic [SLOT_W-1:0] dmod;
	} cmd_t;

	typedef struct packed {
		logic              full;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

	typedef struct packed {
		logic scanning;
		logic busy;
	} back_stat_t;

	typedef logic [SLOT_W-1:0] dmod_tbl_t [DELAY_CODES];

	// delay code reduced modulo the wheel size, built at elaboration
	function automatic dmod_tbl_t build_dmod_tbl();
		dmod_tbl_t tbl;
		for (int i = 0; i < DELAY_CODES; i++) begin
			tbl[i] = SLOT_W'(i % WHEEL_SLOTS);
		end
		return tbl;
	endfunction

	localparam dmod_tbl_t DMOD_TBL = build_dmod_tbl();

	// (a + b) mod wheel size, both operands already below the wheel size
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SLOT_W+1)'(WHEEL_SLOTS)) begin
			s = s - (SLOT_W+1)'(WHEEL_SLOTS);
		end
		return s[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/twtm_front.sv
// ----------------------------------------------------------------------------
// twtm_front
// accepts input words, drops commands for ids beyond the table, reduces the
// delay modulo the wheel size and pushes the command into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module twtm_front import twtm_pkg::*; (
	input  wire logic               s_valid,
	output logic                    s_ready,
	input  wire kind_t              kind,
	input  wire logic [ID_W-1:0]    timer_id,
	input  wire logic [DELAY_W-1:0] delay,
	input  wire queue_stat_t        q_stat,
	output logic                    push,
	output cmd_t                    push_cmd
);

	logic in_range;

	assign in_range = ({1'b0, timer_id} < (ID_W+1)'(MAX_TIMERS));
	assign s_ready  = !q_stat.full;

	// a tick always goes through, other kinds only for ids in the table
	assign push = s_valid && s_ready && ((kind == KIND_TICK) || in_range);

	always_comb begin
		push_cmd.kind = kind;
		push_cmd.idx  = timer_id[IDX_W-1:0];
		push_cmd.dmod = DMOD_TBL[delay];
	end

endmodule

`default_nettype wire

### sv/twtm_queue.sv
// ----------------------------------------------------------------------------
// twtm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module twtm_queue import twtm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	input  wire logic  pop,
	output logic       valid,
	output cmd_t       pop_cmd,
	output queue_stat_t stat
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign valid      = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/twtm_back.sv
// ----------------------------------------------------------------------------
// twtm_back
// executes queued commands against the timer table and scans the table on
// each tick, reporting expiries through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module twtm_back import twtm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire cmd_t       q_cmd,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [ID_W-1:0] expired_id,
	output logic            fired,
	output logic            last,
	output back_stat_t      stat
);

	back_state_t state_q, state_d;

	logic [SLOT_W-1:0]     hand_q;
	logic [MAX_TIMERS-1:0] live_q;
	logic [MAX_TIMERS-1:0] canceled_q;

	logic [SLOT_W-1:0] dly_mem [MAX_TIMERS];
	logic [SLOT_W-1:0] exp_mem [MAX_TIMERS];
	logic [SLOT_W-1:0] dly_rd_q;
	logic [SLOT_W-1:0] exp_rd_q;

	logic [IDX_W-1:0] ref_idx_q;
	logic [IDX_W-1:0] scan_idx_q;

	logic             held_valid_q;
	logic [IDX_W-1:0] held_idx_q;
	logic             held_fired_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_fired_q;
	logic             out_last_q;

	logic              out_free;
	logic              match;
	logic              do_add, do_cancel, do_refresh_rd, do_tick;
	logic              exp_we;
	logic [IDX_W-1:0]  exp_waddr;
	logic [SLOT_W-1:0] exp_wdata;
	logic              exp_re;
	logic              hit;
	logic              flush;
	logic              scan_next;

	assign out_free = !out_valid_q || out_ready;
	assign match    = live_q[scan_idx_q] && (exp_rd_q == hand_q);

	always_comb begin
		state_d       = state_q;
		pop           = 1'b0;
		do_add        = 1'b0;
		do_cancel     = 1'b0;
		do_refresh_rd = 1'b0;
		do_tick       = 1'b0;
		exp_we        = 1'b0;
		exp_waddr     = q_cmd.idx;
		exp_wdata     = slot_add(hand_q, q_cmd.dmod);
		exp_re        = 1'b0;
		hit           = 1'b0;
		flush         = 1'b0;
		scan_next     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (q_cmd.kind)
						KIND_ADD: begin
							do_add = 1'b1;
							exp_we = 1'b1;
						end
						KIND_REFRESH: begin
							if (live_q[q_cmd.idx]) begin
								do_refresh_rd = 1'b1;
								state_d       = ST_REFRESH;
							end
						end
						KIND_CANCEL: begin
							do_cancel = live_q[q_cmd.idx];
						end
						KIND_TICK: begin
							do_tick = 1'b1;
							state_d = ST_SCAN_RD;
						end
						default: ;
					endcase
				end
			end
			ST_REFRESH: begin
				exp_we    = 1'b1;
				exp_waddr = ref_idx_q;
				exp_wdata = slot_add(hand_q, dly_rd_q);
				state_d   = ST_IDLE;
			end
			ST_SCAN_RD: begin
				exp_re  = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				// a second hit pushes the held one out, so wait for room
				if (!(match && held_valid_q && !out_free)) begin
					hit = match;
					if (scan_idx_q == IDX_W'(MAX_TIMERS - 1)) begin
						state_d = ST_SCAN_END;
					end else begin
						scan_next = 1'b1;
						state_d   = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_END: begin
				if (!held_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table memories
	always_ff @(posedge clk) begin
		if (do_add) begin
			dly_mem[q_cmd.idx] <= q_cmd.dmod;
		end
		if (do_refresh_rd) begin
			dly_rd_q <= dly_mem[q_cmd.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[exp_waddr] <= exp_wdata;
		end
		if (exp_re) begin
			exp_rd_q <= exp_mem[scan_idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_refresh_rd) begin
			ref_idx_q <= q_cmd.idx;
		end
		if (hit) begin
			held_idx_q   <= scan_idx_q;
			held_fired_q <= !canceled_q[scan_idx_q];
		end
		// the output payload only changes when a held word moves out
		if ((hit && held_valid_q) || flush) begin
			out_idx_q   <= held_idx_q;
			out_fired_q <= held_fired_q;
			out_last_q  <= flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hand_q       <= '0;
			live_q       <= '0;
			canceled_q   <= '0;
			scan_idx_q   <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_tick) begin
				hand_q     <= (hand_q == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : hand_q + 1'b1;
				scan_idx_q <= '0;
			end else if (scan_next) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (do_add) begin
				live_q[q_cmd.idx]     <= 1'b1;
				canceled_q[q_cmd.idx] <= 1'b0;
			end
			if (do_cancel) begin
				canceled_q[q_cmd.idx] <= 1'b1;
			end
			if (hit) begin
				live_q[scan_idx_q]     <= 1'b0;
				canceled_q[scan_idx_q] <= 1'b0;
				held_valid_q           <= 1'b1;
			end else if (flush) begin
				held_valid_q <= 1'b0;
			end
			if ((hit && held_valid_q) || flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign expired_id    = ID_W'(out_idx_q);
	assign fired         = out_fired_q;
	assign last          = out_last_q;
	assign stat.scanning = (state_q == ST_SCAN_RD) || (state_q == ST_SCAN_CHK) ||
		(state_q == ST_SCAN_END);
	assign stat.busy     = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### sv/timing_wheel_timeout_manager_top.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeout_manager_top
// single-level timing wheel that arms, refreshes, cancels and expires timers
// ----------------------------------------------------------------------------
// throughput: input words enter at one per cycle while the 4-word queue has room
// back end: add and cancel complete in ST_IDLE, refresh of a live timer also passes ST_REFRESH (registered read)
// tick: one expiry memory read plus compare per entry, in ST_SCAN_RD then ST_SCAN_CHK
// expiry path: an expiry is held until the next hit or the scan end, then goes to output
// reset: arst_n clears hand, live and cancel bits, queue and output register at once
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module timing_wheel_timeout_manager_top import twtm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // timer_id[5:0], delay[11:6], zero fill
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // expired_id[5:0], zero fill
	output logic [0:0]       m_tuser,   // fired[0]
	output logic             m_tlast
);

	// front to queue
	logic        q_push;
	cmd_t        q_push_cmd;
	queue_stat_t q_stat;

	// queue to back
	logic        q_valid;
	logic        q_pop;
	cmd_t        q_pop_cmd;

	back_stat_t      bk_stat;
	logic [ID_W-1:0] expired_id;
	logic            fired;

	// classify and filter incoming words
	twtm_front u_front (
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.kind     (kind_t'(s_tuser[KIND_W-1:0])),
		.timer_id (s_tdata[ID_W-1:0]),
		.delay    (s_tdata[ID_W+DELAY_W-1:ID_W]),
		.q_stat   (q_stat),
		.push     (q_push),
		.push_cmd (q_push_cmd)
	);

	// decouples the front from long tick scans
	twtm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_cmd  (q_pop_cmd),
		.stat     (q_stat)
	);

	// timer table, wheel hand and expiry scan
	twtm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_pop_cmd),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.expired_id (expired_id),
		.fired      (fired),
		.last       (m_tlast),
		.stat       (bk_stat)
	);

	// output word packing
	assign m_tdata    = {{(8-ID_W){1'b0}}, expired_id};
	assign m_tuser[0] = fired;

	// no command leaves the queue while a tick scan runs
	`ASSERT_NEVER(a_no_pop_in_scan, bk_stat.scanning && q_pop, "queue popped during scan")
	// a new output word only comes from a tick scan
	`ASSERT_CLK(a_out_from_scan, $rose(m_tvalid) |-> $past(bk_stat.scanning), "stray output word")
	// the front never pushes into a full queue
	`ASSERT_NEVER(a_no_overflow, q_push && q_stat.full, "queue overflow")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stream-level check of the timing wheel timeout manager: directed and random
// add / refresh / cancel / tick words, expiries predicted from a local copy of
// the wheel state and compared word by word, with bursty input and a stalling
// output side that includes one long hold-off
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import twtm_pkg::*;

	localparam int RANDOM_WORDS   = 400;
	localparam int HOLD_AT_WORD   = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 2 * (2 * MAX_TIMERS + 1) + 40;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		kind_t                kind;
		logic [ID_W-1:0]      id;
		logic [DELAY_W-1:0]   dly;
	} timer_cmd_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic            fired;
		logic            last;
	} expiry_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // timer_id[5:0], delay[11:6], zero fill
	logic [1:0]  s_tuser  = '0;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // expired_id[5:0], zero fill
	logic [0:0]  m_tuser;         // fired[0]
	logic        m_tlast;

	timing_wheel_timeout_manager_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// words waiting to be offered, and expiries waiting to come out
	timer_cmd_t pending_cmds[$];
	expiry_t    expiry_due[$];

	int n_queued   = 0;
	int n_accepted = 0;
	int n_errors   = 0;

	// local copy of the wheel
	int                 wheel_hand = 0;
	bit                 armed      [MAX_TIMERS];
	bit                 muted      [MAX_TIMERS];
	logic [DELAY_W-1:0] held_delay [MAX_TIMERS];
	int                 due_slot   [MAX_TIMERS];

	initial begin
		for (int i = 0; i < MAX_TIMERS; i++) begin
			armed[i]      = 1'b0;
			muted[i]      = 1'b0;
			held_delay[i] = '0;
			due_slot[i]   = 0;
		end
	end

	// apply one accepted word to the wheel copy, queue the expiries it causes
	task automatic wheel_apply(input timer_cmd_t c);
		int      hits;
		int      k;
		expiry_t e;
		if (c.kind == KIND_TICK) begin
			wheel_hand = (wheel_hand + 1) % WHEEL_SLOTS;
			hits = 0;
			for (int i = 0; i < MAX_TIMERS; i++) begin
				if (armed[i] && due_slot[i] == wheel_hand) hits++;
			end
			// expiries leave in increasing id order, last one of the tick is marked
			k = 0;
			for (int i = 0; i < MAX_TIMERS; i++) begin
				if (armed[i] && due_slot[i] == wheel_hand) begin
					e.id    = ID_W'(i);
					e.fired = !muted[i];
					e.last  = (k == hits - 1);
					expiry_due = {expiry_due, e};
					armed[i] = 1'b0;
					muted[i] = 1'b0;
					k++;
				end
			end
		end else if (int'(c.id) < MAX_TIMERS) begin
			case (c.kind)
				KIND_ADD: begin
					// re-adding a live id replaces it and clears its cancel mark
					armed[c.id]      = 1'b1;
					muted[c.id]      = 1'b0;
					held_delay[c.id] = c.dly;
					due_slot[c.id]   = (wheel_hand + int'(c.dly)) % WHEEL_SLOTS;
				end
				KIND_REFRESH: begin
					if (armed[c.id])
						due_slot[c.id] = (wheel_hand + int'(held_delay[c.id])) % WHEEL_SLOTS;
				end
				KIND_CANCEL: begin
					if (armed[c.id]) muted[c.id] = 1'b1;
				end
				default: ;
			endcase
		end
	endtask

	task automatic queue_cmd(input kind_t kind, input int id, input int dly);
		timer_cmd_t c;
		c.kind = kind;
		c.id   = ID_W'(id);
		c.dly  = DELAY_W'(dly);
		pending_cmds = {pending_cmds, c};
		n_queued++;
	endtask

	// ------------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [ID_W-1:0] recent_ids[$];
		logic [ID_W-1:0] pick;
		logic [ID_W-1:0] base;
		int              dly;
		int              r;
		int              n_group;
		bit              full_group_done;

		full_group_done = 1'b0;

		// directed part: id and delay extremes, all kinds, the corner cases
		queue_cmd(KIND_ADD, 0, 1);
		queue_cmd(KIND_ADD, 63, 1);
		queue_cmd(KIND_CANCEL, 63, 0);
		queue_cmd(KIND_CANCEL, 63, 0);     // cancel of an already canceled timer
		queue_cmd(KIND_REFRESH, 5, 0);     // refresh of a timer that is not live
		queue_cmd(KIND_CANCEL, 6, 0);      // cancel of a timer that is not live
		queue_cmd(KIND_TICK, 0, 0);        // two expiries, the second one muted
		queue_cmd(KIND_ADD, 10, 63);       // delay above the wheel size wraps
		queue_cmd(KIND_ADD, 11, 60);
		queue_cmd(KIND_ADD, 12, 0);        // zero delay: a whole revolution
		queue_cmd(KIND_ADD, 13, 2);
		queue_cmd(KIND_CANCEL, 13, 0);
		queue_cmd(KIND_ADD, 13, 2);        // re-add of a live id replaces it
		queue_cmd(KIND_ADD, 20, 3);
		queue_cmd(KIND_TICK, 0, 0);        // tick with nothing due
		queue_cmd(KIND_REFRESH, 20, 0);
		queue_cmd(KIND_TICK, 0, 0);
		queue_cmd(KIND_TICK, 0, 0);
		queue_cmd(KIND_TICK, 0, 0);
		queue_cmd(KIND_ADD, 42, 59);
		queue_cmd(KIND_REFRESH, 42, 7);
		queue_cmd(KIND_TICK, 63, 63);

		// random part: mostly live ids so refresh and cancel take effect
		while (n_queued < RANDOM_WORDS + 22) begin
			r = $urandom_range(0, 99);
			if (!full_group_done && n_queued > 200) begin
				// every timer armed on the same slot: the longest tick
				full_group_done = 1'b1;
				dly = $urandom_range(1, 3);
				for (int i = 0; i < MAX_TIMERS; i++) queue_cmd(KIND_ADD, i, dly);
			end else if (r < 4) begin
				n_group = $urandom_range(4, 20);
				base    = ID_W'($urandom_range(0, 63));
				dly     = $urandom_range(1, 3);
				for (int i = 0; i < n_group; i++) begin
					queue_cmd(KIND_ADD, int'(ID_W'(base + ID_W'(i))), dly);
					recent_ids = {recent_ids, ID_W'(base + ID_W'(i))};
				end
			end else if (r < 40) begin
				pick = ($urandom_range(0, 9) < 3) ? ID_W'($urandom_range(0, 63))
				                                 : ID_W'($urandom_range(0, 15));
				r = $urandom_range(0, 9);
				if (r < 6)      dly = $urandom_range(1, 6);
				else if (r < 9) dly = $urandom_range(0, 63);
				else begin
					case ($urandom_range(0, 3))
						0:       dly = 0;
						1:       dly = 59;
						2:       dly = 60;
						default: dly = 63;
					endcase
				end
				queue_cmd(KIND_ADD, pick, dly);
				recent_ids = {recent_ids, pick};
			end else if (r < 68) begin
				if (recent_ids.size() == 0 || $urandom_range(0, 99) < 15)
					pick = ID_W'($urandom_range(0, 63));
				else
					pick = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
				// unused delay bits carry noise
				queue_cmd((r < 55) ? KIND_REFRESH : KIND_CANCEL, pick, $urandom_range(0, 63));
			end else begin
				queue_cmd(KIND_TICK, $urandom_range(0, 63), $urandom_range(0, 63));
			end
			while (recent_ids.size() > 8) void'(recent_ids.pop_front());
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_queued) @(posedge clk);
		while (expiry_due.size() != 0) @(posedge clk);
		// a trailing tick may still be scanning; any stray word gets caught here
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// input driver: bursts of random length with random gaps
	// ------------------------------------------------------------------------
	timer_cmd_t cur_cmd;
	int         burst_left = 1;
	int         gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				wheel_apply(cur_cmd);
				n_accepted++;
			end
			// hold the current word while it is being stalled
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, cur_cmd.dly, cur_cmd.id};
					s_tuser  <= cur_cmd.kind;
					burst_left--;
					if (burst_left <= 0) begin
						// some bursts are long stretches with no idling
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
						                                        : $urandom_range(1, 6);
						gap_left   = $urandom_range(1, 10);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// output side: stall modes that change now and then, one long hold-off
	// ------------------------------------------------------------------------
	int rx_mode   = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && n_accepted >= HOLD_AT_WORD) begin
				// sender keeps going, so the queue fills and s_tready drops
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 80);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// output checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		expiry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expiry_due.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual id %0d fired %0d last %0d",
					$time, m_tdata[ID_W-1:0], m_tuser[0], m_tlast);
				n_errors++;
			end else begin
				want = expiry_due.pop_front();
				if (m_tdata[ID_W-1:0] !== want.id) begin
					$display("%0t: expired_id mismatch: expected %0d, actual %0d",
						$time, want.id, m_tdata[ID_W-1:0]);
					n_errors++;
				end
				if (m_tuser[0] !== want.fired) begin
					$display("%0t: fired mismatch on id %0d: expected %0d, actual %0d",
						$time, want.id, want.fired, m_tuser[0]);
					n_errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last mismatch on id %0d: expected %0d, actual %0d",
						$time, want.id, want.last, m_tlast);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long with no word moving on either side
	// ------------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
